FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold a stalled signal until the beat is taken
`define ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy)) |=> $stable(sig)) else $error("hold check failed");

// simple implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(a) |-> (b)) else $error("implication check failed");

`endif

FILE: hw/rtl/lsd_pkg.sv
package lsd_pkg;

	localparam int VAL_W = 32;
	localparam int POS_W = 5;
	localparam int CNT_W = 6;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_DEDUPE = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic rot;
		logic app;
		logic clr;
		logic copy;
	} ctl_t;

endpackage

FILE: hw/rtl/lsd_cell.sv
module lsd_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsd_pkg::ctl_t               ctl,
	input  logic [CW-1:0]               count,
	input  logic [lsd_pkg::VAL_W-1:0]   in_value,
	input  logic [lsd_pkg::VAL_W-1:0]   head,
	input  logic [lsd_pkg::VAL_W-1:0]   nxt,
	input  logic                        tok_in_v,
	input  logic [lsd_pkg::VAL_W-1:0]   tok_in_d,
	output logic [lsd_pkg::VAL_W-1:0]   val,
	output logic                        tok_out_v,
	output logic [lsd_pkg::VAL_W-1:0]   tok_out_d,
	output logic                        store,
	output logic                        busy
);
	import lsd_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] kept_val_q;
	logic             keep_q;
	logic             tok_v_q;
	logic [VAL_W-1:0] tok_d_q;
	logic             hit;

	assign hit       = keep_q && (kept_val_q == tok_d_q);
	assign store     = tok_v_q && !keep_q;
	assign tok_out_v = tok_v_q && keep_q && !hit;
	assign tok_out_d = tok_d_q;
	assign busy      = tok_v_q;
	assign val       = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q  <= 1'b0;
			tok_v_q <= 1'b0;
		end else if (ctl.clr) begin
			keep_q  <= 1'b0;
			tok_v_q <= 1'b0;
		end else begin
			if (store)
				keep_q <= 1'b1;
			tok_v_q <= tok_in_v;
		end
	end

	always_ff @(posedge clk) begin
		tok_d_q <= tok_in_d;
		if (store)
			kept_val_q <= tok_d_q;
		if (ctl.copy)
			val_q <= kept_val_q;
		else if (ctl.app && (IDX_C == count))
			val_q <= in_value;
		else if (ctl.rot && (IDX_C < count))
			val_q <= ((IDX_C + CW'(1)) == count) ? head : nxt;
	end

endmodule

FILE: hw/rtl/lsd_ctrl.sv
module lsd_ctrl #(
	parameter int DEPTH = 32,
	parameter int CW    = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [1:0]                  mode,
	input  logic [lsd_pkg::VAL_W-1:0]   head,
	input  logic                        busy,
	input  logic                        store_any,
	output lsd_pkg::ctl_t               ctl,
	output logic                        feed_v,
	output logic [CW-1:0]               count,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [lsd_pkg::VAL_W-1:0]   out_value,
	output logic [lsd_pkg::POS_W-1:0]   position,
	output logic                        last_of_run,
	output logic [1:0]                  status,
	output logic [lsd_pkg::CNT_W-1:0]   entry_count
);
	import lsd_pkg::*;

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_FEED,
		S_DRAIN,
		S_COPY
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    kept_q;
	logic             out_free;
	logic             acc;
	logic [CW+POS_W-1:0] pos_ext;
	logic [CW+CNT_W-1:0] cnt_ext;
	logic [CW+CNT_W-1:0] kept_ext;
	logic [CW+CNT_W-1:0] inc_ext;
	logic [CW+CNT_W-1:0] dec_ext;

	assign out_free   = !res_valid || res_ready;
	assign item_ready = (state_q == S_IDLE) && out_free;
	assign acc        = item_valid && item_ready;
	assign count      = cnt_q;
	assign pos_ext    = {{POS_W{1'b0}}, idx_q};
	assign cnt_ext    = {{CNT_W{1'b0}}, cnt_q};
	assign kept_ext   = {{CNT_W{1'b0}}, kept_q};
	assign inc_ext    = {{CNT_W{1'b0}}, cnt_q + CW'(1)};
	assign dec_ext    = {{CNT_W{1'b0}}, cnt_q - CW'(1)};

	always_comb begin
		ctl    = '0;
		feed_v = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && (mode_t'(mode) == MODE_APPEND) && (cnt_q != DEPTH_C))
					ctl.app = 1'b1;
				if (acc && (mode_t'(mode) == MODE_DEDUPE) && (cnt_q != '0))
					ctl.clr = 1'b1;
			end
			S_READ:  ctl.rot = out_free;
			S_FEED: begin
				ctl.rot = 1'b1;
				feed_v  = 1'b1;
			end
			S_DRAIN: ctl = '0;
			S_COPY:  ctl.copy = out_free;
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			kept_q      <= '0;
			res_valid   <= 1'b0;
			out_value   <= '0;
			position    <= '0;
			last_of_run <= 1'b0;
			status      <= ST_OK;
			entry_count <= '0;
		end else begin
			if (res_valid && res_ready)
				res_valid <= 1'b0;
			if (store_any)
				kept_q <= kept_q + CW'(1);
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						out_value   <= '0;
						position    <= '0;
						last_of_run <= 1'b1;
						status      <= ST_OK;
						entry_count <= cnt_ext[CNT_W-1:0];
						idx_q       <= '0;
						kept_q      <= '0;
						res_valid   <= 1'b1;
						unique case (mode_t'(mode))
							MODE_APPEND: begin
								if (cnt_q == DEPTH_C) begin
									status <= ST_FULL;
								end else begin
									cnt_q       <= cnt_q + CW'(1);
									entry_count <= inc_ext[CNT_W-1:0];
								end
							end
							MODE_REMOVE: begin
								if (cnt_q == '0) begin
									status <= ST_EMPTY;
								end else begin
									cnt_q       <= cnt_q - CW'(1);
									entry_count <= dec_ext[CNT_W-1:0];
								end
							end
							MODE_DEDUPE: begin
								if (cnt_q != '0) begin
									res_valid <= 1'b0;
									state_q   <= S_FEED;
								end
							end
							MODE_READ: begin
								if (cnt_q == '0) begin
									status <= ST_EMPTY;
								end else begin
									res_valid <= 1'b0;
									state_q   <= S_READ;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_READ: begin
					if (out_free) begin
						res_valid   <= 1'b1;
						out_value   <= head;
						position    <= pos_ext[POS_W-1:0];
						last_of_run <= (idx_q + CW'(1)) == cnt_q;
						status      <= ST_OK;
						entry_count <= cnt_ext[CNT_W-1:0];
						idx_q       <= idx_q + CW'(1);
						if ((idx_q + CW'(1)) == cnt_q)
							state_q <= S_IDLE;
					end
				end
				S_FEED: begin
					idx_q <= idx_q + CW'(1);
					if ((idx_q + CW'(1)) == cnt_q)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!busy)
						state_q <= S_COPY;
				end
				S_COPY: begin
					if (out_free) begin
						res_valid   <= 1'b1;
						out_value   <= '0;
						position    <= '0;
						last_of_run <= 1'b1;
						status      <= ST_OK;
						entry_count <= kept_ext[CNT_W-1:0];
						cnt_q       <= kept_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/list_store_with_dedupe.sv
// Ordered store of signed 32-bit entries, one operation per input beat.
// Input channel: item_valid/item_ready with mode and in_value.
// Output channel: res_valid/res_ready with out_value, position,
// last_of_run, status and entry_count.
// Append and remove-last give one result beat in the cycle after acceptance.
// Readout of N entries gives N beats, one per cycle while the receiver keeps
// up, by rotating the cell row so each entry reaches cell 0 in turn.
// Dedupe feeds the N entries into a token chain that runs through the cells,
// waits until every token has settled (a token stops no deeper than the
// number of tokens ahead of it), then copies all kept values back at once.
// One operation is in flight at a time; a new beat is taken once the
// previous one has produced all its results and the output register is
// free or being emptied.
// A receiver stall holds the output register and halts readout in place.
// Reset empties the store; entry contents are not cleared.
module list_store_with_dedupe #(
	parameter int DEPTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [1:0]                  mode,
	input  logic signed [lsd_pkg::VAL_W-1:0] in_value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic signed [lsd_pkg::VAL_W-1:0] out_value,
	output logic [lsd_pkg::POS_W-1:0]   position,
	output logic                        last_of_run,
	output logic [1:0]                  status,
	output logic [lsd_pkg::CNT_W-1:0]   entry_count
);
	import lsd_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	ctl_t             ctl;
	logic             feed_v;
	logic [CW-1:0]    count;
	logic [VAL_W-1:0] val  [DEPTH];
	logic [VAL_W-1:0] tokd [DEPTH+1];
	logic [DEPTH:0]   tokv;
	logic [DEPTH-1:0] store_v;
	logic [DEPTH-1:0] busy_v;
	logic [VAL_W-1:0] out_raw;
	logic             busy;

	assign tokv[0] = feed_v;
	assign tokd[0] = val[0];
	assign busy    = (|busy_v) || tokv[DEPTH];
	assign out_value = out_raw;

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		logic [VAL_W-1:0] nxt;
		if (j == DEPTH - 1) begin : g_wrap
			assign nxt = val[0];
		end else begin : g_mid
			assign nxt = val[j+1];
		end
		lsd_cell #(
			.IDX(j),
			.CW (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.count    (count),
			.in_value (in_value),
			.head     (val[0]),
			.nxt      (nxt),
			.tok_in_v (tokv[j]),
			.tok_in_d (tokd[j]),
			.val      (val[j]),
			.tok_out_v(tokv[j+1]),
			.tok_out_d(tokd[j+1]),
			.store    (store_v[j]),
			.busy     (busy_v[j])
		);
	end

	lsd_ctrl #(
		.DEPTH(DEPTH),
		.CW   (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.head       (val[0]),
		.busy       (busy),
		.store_any  (|store_v),
		.ctl        (ctl),
		.feed_v     (feed_v),
		.count      (count),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.out_value  (out_raw),
		.position   (position),
		.last_of_run(last_of_run),
		.status     (status),
		.entry_count(entry_count)
	);

endmodule

FILE: hw/rtl/lsd_checker.sv
`include "assert_macros.svh"

module lsd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic [1:0]                  mode,
	input logic [lsd_pkg::VAL_W-1:0]   in_value,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [lsd_pkg::VAL_W-1:0]   out_value,
	input logic [lsd_pkg::POS_W-1:0]   position,
	input logic                        last_of_run,
	input logic [1:0]                  status,
	input logic [lsd_pkg::CNT_W-1:0]   entry_count
);
	import lsd_pkg::*;

	logic [VAL_W+1:0]             in_pay;
	logic [VAL_W+POS_W+CNT_W+2:0] res_pay;
	logic                         status_ok;
	logic                         err_beat;
	logic                         err_shape;
	logic                         mid_run;
	logic                         mid_shape;

	assign in_pay    = {mode, in_value};
	assign res_pay   = {out_value, position, last_of_run, status, entry_count};
	assign status_ok = (status == ST_OK) || (status == ST_EMPTY) || (status == ST_FULL);
	assign err_beat  = res_valid && (status != ST_OK);
	assign err_shape = last_of_run && (out_value == '0) && (position == '0);
	assign mid_run   = res_valid && !last_of_run;
	assign mid_shape = !item_ready && (status == ST_OK);

	`ASSERT_HOLD(a_in_hold, clk, arst_n, item_valid, item_ready, in_pay)

	`ASSERT_HOLD(a_res_hold, clk, arst_n, res_valid, res_ready, res_pay)

	`ASSERT_IMPLY(a_status_code, clk, arst_n, res_valid, status_ok)

	`ASSERT_IMPLY(a_error_is_single, clk, arst_n, err_beat, err_shape)

	`ASSERT_IMPLY(a_no_take_midrun, clk, arst_n, mid_run, mid_shape)

endmodule

bind list_store_with_dedupe lsd_checker u_lsd_checker (.*);
